### hw/rtl/ppki_pkg.sv
// shared types, codes and arithmetic helpers of the particle pool integrator
package ppki_pkg;

  localparam int SLOTS   = 1024;
  localparam int SLOT_AW = $clog2(SLOTS);

  localparam logic [2:0] OP_ADD    = 3'd0;
  localparam logic [2:0] OP_REMOVE = 3'd1;
  localparam logic [2:0] OP_SETPOS = 3'd2;
  localparam logic [2:0] OP_ADDFRC = 3'd3;
  localparam logic [2:0] OP_READ   = 3'd4;
  localparam logic [2:0] OP_TICK   = 3'd5;

  localparam logic [2:0] WR_NONE   = 3'd0;
  localparam logic [2:0] WR_CLEAR  = 3'd1;
  localparam logic [2:0] WR_ADD    = 3'd2;
  localparam logic [2:0] WR_REMOVE = 3'd3;
  localparam logic [2:0] WR_SETPOS = 3'd4;
  localparam logic [2:0] WR_ADDFRC = 3'd5;
  localparam logic [2:0] WR_TICK   = 3'd6;

  typedef logic [2:0][31:0] vec3_t;

  typedef struct packed {
    logic               rd_en;
    logic               rd_in;    // read address from the incoming word
    logic [SLOT_AW-1:0] addr;     // sweep / tick slot
    logic [2:0]         wr_kind;
    logic               latch;
    logic               out_load;
    logic               tk_d2;
    logic               tk_m1;
    logic               tk_m2;
    logic               tk_m3;
    logic               tk_m4;
    logic [1:0]         axis;
  } cmd_t;

  typedef struct packed {
    logic [2:0] op;
    logic       act;
    logic       out_busy;
  } sts_t;

  function automatic logic [65:0] sx66(input logic [31:0] x);
    return {{34{x[31]}}, x};
  endfunction

  // divide by 2^k, round to nearest, ties away from zero
  function automatic logic [65:0] rnd(input logic [65:0] x, input int k);
    logic        neg;
    logic [65:0] mag;
    logic [65:0] r;
    neg = x[65];
    mag = neg ? (~x + 66'd1) : x;
    r   = (mag + (66'd1 << (k - 1))) >> k;
    return neg ? (~r + 66'd1) : r;
  endfunction

  function automatic logic [31:0] sat32(input logic [65:0] x);
    logic [31:0] y;
    if ($signed(x) > $signed(66'sd2147483647)) begin
      y = 32'h7FFF_FFFF;
    end else if ($signed(x) < -$signed(66'sd2147483648)) begin
      y = 32'h8000_0000;
    end else begin
      y = x[31:0];
    end
    return y;
  endfunction

endpackage

### hw/rtl/ppki_if.sv
// channel interfaces of the particle pool integrator
interface ppki_in_if;
  logic               valid;
  logic               ready;
  logic [2:0]         op;
  logic [9:0]         slot;
  logic [1:0]         axis;
  logic signed [31:0] value;
  logic [31:0]        inv_mass;
  logic [15:0]        dt;
  modport source(output valid, op, slot, axis, value, inv_mass, dt, input ready);
  modport sink(input valid, op, slot, axis, value, inv_mass, dt, output ready);
endinterface

interface ppki_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] read_value;
  logic               slot_active;
  modport source(output valid, read_value, slot_active, input ready);
  modport sink(input valid, read_value, slot_active, output ready);
endinterface

### hw/rtl/ppki_datapath.sv
// slot memories, tick arithmetic and the result register
module ppki_datapath (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [2:0]         in_op,
  input  logic [9:0]         in_slot,
  input  logic [1:0]         in_axis,
  input  logic [31:0]        in_value,
  input  logic [31:0]        in_inv_mass,
  input  logic [15:0]        in_dt,
  ppki_out_if.source         out_ch,
  input  ppki_pkg::cmd_t     cmd,
  output ppki_pkg::sts_t     sts
);

  ppki_pkg::vec3_t pos_mem [ppki_pkg::SLOTS];
  ppki_pkg::vec3_t vel_mem [ppki_pkg::SLOTS];
  ppki_pkg::vec3_t frc_mem [ppki_pkg::SLOTS];
  logic [31:0]     im_mem  [ppki_pkg::SLOTS];
  logic            act_mem [ppki_pkg::SLOTS];

  ppki_pkg::vec3_t pos_q_r, vel_q_r, frc_q_r;
  logic [31:0]     im_q_r;
  logic            act_q_r;

  logic [2:0]  op_r;
  logic [9:0]  slot_r;
  logic [1:0]  axis_r;
  logic [31:0] value_r, im_in_r;
  logic [15:0] dt_r;
  logic [31:0] d2_r;

  logic [65:0] fi_r, vd_r, ad2_r, ad_r;
  logic [31:0] a_r;
  ppki_pkg::vec3_t pn_r, vn_r;

  logic                        out_valid_r, out_valid_nxt;
  logic [31:0]                 out_value_r;
  logic                        out_active_r;

  logic [ppki_pkg::SLOT_AW-1:0] ra, wa;
  logic in_range, live, ax_ok;
  logic pos_we, vel_we, frc_we, im_we, act_we;
  ppki_pkg::vec3_t pos_wd, vel_wd, frc_wd;
  logic [31:0] im_wd;
  logic        act_wd;

  assign in_range = ({22'd0, slot_r} < 32'(ppki_pkg::SLOTS));
  assign live     = in_range && act_q_r;
  assign ax_ok    = (axis_r != 2'd3);
  assign ra = cmd.rd_in ? ppki_pkg::SLOT_AW'(in_slot) : cmd.addr;
  assign wa = (cmd.wr_kind == ppki_pkg::WR_CLEAR || cmd.wr_kind == ppki_pkg::WR_TICK)
              ? cmd.addr : ppki_pkg::SLOT_AW'(slot_r);

  always_comb begin
    pos_we = 1'b0; vel_we = 1'b0; frc_we = 1'b0; im_we = 1'b0; act_we = 1'b0;
    pos_wd = '0; vel_wd = '0; frc_wd = '0; im_wd = im_in_r; act_wd = 1'b0;
    case (cmd.wr_kind)
      ppki_pkg::WR_CLEAR: begin
        act_we = 1'b1;
      end
      ppki_pkg::WR_ADD: begin
        pos_we = in_range; vel_we = in_range; frc_we = in_range; im_we = in_range;
        act_we = in_range; act_wd = 1'b1;
      end
      ppki_pkg::WR_REMOVE: begin
        act_we = in_range;
      end
      ppki_pkg::WR_SETPOS: begin
        pos_wd = pos_q_r;
        pos_wd[axis_r] = value_r;
        pos_we = live && ax_ok;
      end
      ppki_pkg::WR_ADDFRC: begin
        frc_wd = frc_q_r;
        frc_wd[axis_r] = ppki_pkg::sat32(ppki_pkg::sx66(frc_q_r[axis_r])
                                         + ppki_pkg::sx66(value_r));
        frc_we = live && ax_ok;
      end
      ppki_pkg::WR_TICK: begin
        pos_wd = pn_r; vel_wd = vn_r;
        pos_we = 1'b1; vel_we = 1'b1; frc_we = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (pos_we) pos_mem[wa] <= pos_wd;
    if (vel_we) vel_mem[wa] <= vel_wd;
    if (frc_we) frc_mem[wa] <= frc_wd;
    if (im_we)  im_mem[wa]  <= im_wd;
    if (act_we) act_mem[wa] <= act_wd;
    if (cmd.rd_en) begin
      pos_q_r <= pos_mem[ra];
      vel_q_r <= vel_mem[ra];
      frc_q_r <= frc_mem[ra];
      im_q_r  <= im_mem[ra];
      act_q_r <= act_mem[ra];
    end
  end

  // latched word and tick pipeline
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      op_r    <= in_op;
      slot_r  <= in_slot;
      axis_r  <= in_axis;
      value_r <= in_value;
      im_in_r <= in_inv_mass;
      dt_r    <= in_dt;
    end
    if (cmd.tk_d2) d2_r <= 32'(dt_r * dt_r);
    if (cmd.tk_m1) fi_r <= ppki_pkg::sx66(frc_q_r[cmd.axis]) * {34'd0, im_q_r};
    if (cmd.tk_m2) a_r  <= ppki_pkg::sat32(ppki_pkg::rnd(fi_r, 16));
    if (cmd.tk_m3) begin
      vd_r  <= ppki_pkg::sx66(vel_q_r[cmd.axis]) * {50'd0, dt_r};
      ad2_r <= ppki_pkg::sx66(a_r) * {34'd0, d2_r};
      ad_r  <= ppki_pkg::sx66(a_r) * {50'd0, dt_r};
    end
    if (cmd.tk_m4) begin
      pn_r[cmd.axis] <= ppki_pkg::sat32(ppki_pkg::sx66(pos_q_r[cmd.axis])
                        + ppki_pkg::rnd(vd_r, 16) + ppki_pkg::rnd(ad2_r, 33));
      vn_r[cmd.axis] <= ppki_pkg::sat32(ppki_pkg::sx66(vel_q_r[cmd.axis])
                        + ppki_pkg::rnd(ad_r, 16));
    end
    if (cmd.out_load) begin
      out_value_r  <= (live && ax_ok) ? pos_q_r[axis_r] : 32'd0;
      out_active_r <= live;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.read_value  = out_value_r;
  assign out_ch.slot_active = out_active_r;

  assign sts.op       = op_r;
  assign sts.act      = act_q_r;
  assign sts.out_busy = out_valid_r && !out_ch.ready;

endmodule

### hw/rtl/ppki_ctrl.sv
// sequencer for access operations, tick sweep and the clearing pass
module ppki_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  input  logic [2:0]     in_op,
  output logic           in_ready,
  input  ppki_pkg::sts_t sts,
  output ppki_pkg::cmd_t cmd
);

  localparam logic [3:0] ST_CLR   = 4'd0;
  localparam logic [3:0] ST_IDLE  = 4'd1;
  localparam logic [3:0] ST_EX    = 4'd2;
  localparam logic [3:0] ST_TK_D2 = 4'd3;
  localparam logic [3:0] ST_TK_RD = 4'd4;
  localparam logic [3:0] ST_TK_CK = 4'd5;
  localparam logic [3:0] ST_TK_M1 = 4'd6;
  localparam logic [3:0] ST_TK_M2 = 4'd7;
  localparam logic [3:0] ST_TK_M3 = 4'd8;
  localparam logic [3:0] ST_TK_M4 = 4'd9;
  localparam logic [3:0] ST_TK_WB = 4'd10;

  logic [3:0] state_r, state_nxt;
  logic [ppki_pkg::SLOT_AW-1:0] cnt_r, cnt_nxt;
  logic [1:0] axis_r, axis_nxt;
  logic last;

  assign last     = (cnt_r == ppki_pkg::SLOT_AW'(ppki_pkg::SLOTS - 1));
  assign in_ready = (state_r == ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    axis_nxt  = axis_r;
    cmd       = '0;
    cmd.addr  = cnt_r;
    cmd.axis  = axis_r;
    case (state_r)
      ST_CLR: begin
        cmd.wr_kind = ppki_pkg::WR_CLEAR;
        cnt_nxt = cnt_r + 1'b1;
        if (last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid) begin
          cmd.latch = 1'b1;
          cmd.rd_en = 1'b1;
          cmd.rd_in = 1'b1;
          state_nxt = (in_op == ppki_pkg::OP_TICK) ? ST_TK_D2 : ST_EX;
        end
      end
      ST_EX: begin
        case (sts.op)
          ppki_pkg::OP_ADD:    cmd.wr_kind = ppki_pkg::WR_ADD;
          ppki_pkg::OP_REMOVE: cmd.wr_kind = ppki_pkg::WR_REMOVE;
          ppki_pkg::OP_SETPOS: cmd.wr_kind = ppki_pkg::WR_SETPOS;
          ppki_pkg::OP_ADDFRC: cmd.wr_kind = ppki_pkg::WR_ADDFRC;
          default:             cmd.wr_kind = ppki_pkg::WR_NONE;
        endcase
        if (sts.op == ppki_pkg::OP_READ) begin
          if (!sts.out_busy) begin
            cmd.out_load = 1'b1;
            state_nxt = ST_IDLE;
          end
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_TK_D2: begin
        cmd.tk_d2 = 1'b1;
        cnt_nxt = '0;
        state_nxt = ST_TK_RD;
      end
      ST_TK_RD: begin
        cmd.rd_en = 1'b1;
        state_nxt = ST_TK_CK;
      end
      ST_TK_CK: begin
        axis_nxt = 2'd0;
        if (sts.act) begin
          state_nxt = ST_TK_M1;
        end else if (last) begin
          state_nxt = ST_IDLE;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
          state_nxt = ST_TK_RD;
        end
      end
      ST_TK_M1: begin
        cmd.tk_m1 = 1'b1;
        state_nxt = ST_TK_M2;
      end
      ST_TK_M2: begin
        cmd.tk_m2 = 1'b1;
        state_nxt = ST_TK_M3;
      end
      ST_TK_M3: begin
        cmd.tk_m3 = 1'b1;
        state_nxt = ST_TK_M4;
      end
      ST_TK_M4: begin
        cmd.tk_m4 = 1'b1;
        if (axis_r == 2'd2) begin
          state_nxt = ST_TK_WB;
        end else begin
          axis_nxt = axis_r + 1'b1;
          state_nxt = ST_TK_M1;
        end
      end
      ST_TK_WB: begin
        cmd.wr_kind = ppki_pkg::WR_TICK;
        if (last) begin
          state_nxt = ST_IDLE;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
          state_nxt = ST_TK_RD;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLR;
      cnt_r   <= '0;
      axis_r  <= 2'd0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      axis_r  <= axis_nxt;
    end
  end

endmodule

### hw/rtl/particle_pool_kinematic_integrator_top.sv
// top level of the particle pool kinematic integrator
// usage:
// - in_ch carries one command word: op, slot, axis, value, inv_mass, dt
// - out_ch carries one result word (read_value, slot_active) per read op only
// - add, remove, set position, add force and read go through an accept step
//   that reads the slot row from the slot memories and an execute step that
//   updates it or loads the result register
// - a tick forms dt squared, then sweeps all 1024 slots, reading each slot row
//   and checking its live flag; a live slot then runs its three axes through
//   the shared multiply/round unit (M1 to M4 per axis) and writes back
// - a read result passes the execute step, then the result register, to out_ch
// - after reset a clearing pass over all slots resets the live flags; in_ch
//   ready stays low during it; position, velocity, force and inverse mass
//   memories are not cleared and are written by add before first use
// - the result register holds a word while out_ch stalls; the block keeps
//   taking words and only waits when a second read result would be loaded
module particle_pool_kinematic_integrator_top (
  input  logic        clk,
  input  logic        rst_n,
  ppki_in_if.sink     in_ch,
  ppki_out_if.source  out_ch
);

  ppki_pkg::cmd_t cmd;
  ppki_pkg::sts_t sts;
  logic           in_ready;

  assign in_ch.ready = in_ready;

  // sequencer: state, slot counter, axis counter
  ppki_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_op    (in_ch.op),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // memories, arithmetic, result register
  ppki_datapath u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_op       (in_ch.op),
    .in_slot     (in_ch.slot),
    .in_axis     (in_ch.axis),
    .in_value    (in_ch.value),
    .in_inv_mass (in_ch.inv_mass),
    .in_dt       (in_ch.dt),
    .out_ch      (out_ch),
    .cmd         (cmd),
    .sts         (sts)
  );

  // one word in flight at a time
  a_one_word: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
    else $error("word accepted while busy");

  // a result is loaded only into a free or draining result register
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> !(out_ch.valid && !out_ch.ready))
    else $error("result register overwritten");

  // a loaded result shows up on the next cycle
  a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |=> out_ch.valid)
    else $error("loaded result not presented");

endmodule
